FILE: design/rtm_pkg.sv
// Package for the repetition timing monitor.
// Holds the event kind codes, run modes, error bits and the window length in seconds.
// No dependencies.
package rtm_pkg;

  localparam int unsigned WINDOW_SECONDS = 5;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_BEGIN = 3'd1,
    KIND_END   = 3'd2,
    KIND_BYTES = 3'd3,
    KIND_POLL  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_UNINIT    = 2'd0,
    MODE_TESTING   = 2'd1,
    MODE_COMPLETED = 2'd2,
    MODE_ERROR     = 2'd3
  } mode_e;

  localparam logic [3:0] ERR_TARGET     = 4'b0001;
  localparam logic [3:0] ERR_FREQ       = 4'b0010;
  localparam logic [3:0] ERR_UNBALANCED = 4'b0100;
  localparam logic [3:0] ERR_BYTES      = 4'b1000;

endpackage

FILE: design/repetition_timing_monitor_unit.sv
// Repetition timing monitor: event stage, run state and result register.
// Depends on rtm_pkg.
//
// Usage: every input word is one timestamped event (start wave, begin timing, end
// timing, add bytes, poll). Each accepted word produces exactly one result word
// with the run mode, the errors raised by that event, a new-minimum flag and the
// trial count, minimum, maximum and sum of trial times after the event.
// An event is captured in the input register, evaluated against the run state in
// one pass of adder/compare logic, and the result is held in the output register
// while the run state updates on the same edge. Throughput is one event per cycle
// while the receiver does not stall; the next event sees the state left by the
// previous one because both are updated on the same edge.
// When the receiver stalls, the result stays in the output register and the
// event in the input register waits; in_stall_o rises only when both are full.
// Reset clears the mode to uninitialized, zeroes all counters and accumulators,
// and empties both registers. The first start wave sets the minimum to all ones.
module repetition_timing_monitor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] timestamp_i,
  input  logic [63:0] byte_amount_i,
  input  logic [63:0] target_bytes_i,
  input  logic [31:0] timer_frequency_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        still_testing_o,
  output logic [1:0]  mode_now_o,
  output logic [3:0]  error_mask_o,
  output logic        new_minimum_o,
  output logic [63:0] trial_count_o,
  output logic [63:0] min_ticks_o,
  output logic [63:0] max_ticks_o,
  output logic [63:0] sum_ticks_o
);
  import rtm_pkg::*;

  // Input register.
  logic        ev_valid_q;
  kind_e       ev_kind_q;
  logic [63:0] ev_ts_q;
  logic [63:0] ev_amount_q;
  logic [63:0] ev_target_q;
  logic [31:0] ev_freq_q;

  // Run state.
  mode_e       mode_q, mode_d;
  logic [63:0] tgt_q, tgt_d;
  logic [31:0] freq_q, freq_d;
  logic [63:0] win_len_q, win_len_d;
  logic [63:0] win_start_q, win_start_d;
  logic [31:0] open_q, open_d;
  logic [31:0] close_q, close_d;
  logic [63:0] trial_time_q, trial_time_d;
  logic [63:0] trial_bytes_q, trial_bytes_d;
  logic [63:0] count_q, count_d;
  logic [63:0] sum_q, sum_d;
  logic [63:0] max_q, max_d;
  logic [63:0] min_q, min_d;

  // Output register.
  logic        out_valid_q;
  mode_e       res_mode_q;
  logic [3:0]  res_err_q;
  logic        res_newmin_q;

  logic [3:0]  errs;
  logic        newmin;
  logic        expired;
  logic        out_ready;
  logic        fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = ev_valid_q && out_ready;
  assign in_stall_o = ev_valid_q && !out_ready;

  always_comb begin
    mode_d        = mode_q;
    tgt_d         = tgt_q;
    freq_d        = freq_q;
    win_len_d     = win_len_q;
    win_start_d   = win_start_q;
    open_d        = open_q;
    close_d       = close_q;
    trial_time_d  = trial_time_q;
    trial_bytes_d = trial_bytes_q;
    count_d       = count_q;
    sum_d         = sum_q;
    max_d         = max_q;
    min_d         = min_q;
    errs          = '0;
    newmin        = 1'b0;
    expired       = (ev_ts_q - win_start_q) > win_len_q;

    case (ev_kind_q)
      KIND_START: begin
        if (mode_q == MODE_UNINIT) begin
          mode_d = MODE_TESTING;
          tgt_d  = ev_target_q;
          freq_d = ev_freq_q;
          min_d  = '1;
        end else if (mode_q == MODE_COMPLETED) begin
          if (tgt_q != ev_target_q) errs = errs | ERR_TARGET;
          if (freq_q != ev_freq_q) errs = errs | ERR_FREQ;
          mode_d = (errs != '0) ? MODE_ERROR : MODE_TESTING;
        end
        win_len_d   = 64'(64'(ev_freq_q) * 64'(WINDOW_SECONDS));
        win_start_d = ev_ts_q;
      end
      KIND_BEGIN: begin
        open_d       = open_q + 32'd1;
        trial_time_d = trial_time_q - ev_ts_q;
      end
      KIND_END: begin
        close_d      = close_q + 32'd1;
        trial_time_d = trial_time_q + ev_ts_q;
      end
      KIND_BYTES: begin
        trial_bytes_d = trial_bytes_q + ev_amount_q;
      end
      KIND_POLL: begin
        if (mode_q == MODE_TESTING) begin
          if (open_q != '0) begin
            if (open_q != close_q) errs = errs | ERR_UNBALANCED;
            if (trial_bytes_q != tgt_q) errs = errs | ERR_BYTES;
            if (errs != '0) begin
              mode_d = MODE_ERROR;
            end else begin
              count_d = count_q + 64'd1;
              sum_d   = sum_q + trial_time_q;
              if (max_q < trial_time_q) max_d = trial_time_q;
              if (min_q > trial_time_q) begin
                min_d       = trial_time_q;
                win_start_d = ev_ts_q;
                newmin      = 1'b1;
              end
              open_d        = '0;
              close_d       = '0;
              trial_time_d  = '0;
              trial_bytes_d = '0;
            end
          end
          // A new minimum restarts the window at this timestamp, so it cannot expire.
          if (expired && !newmin) mode_d = MODE_COMPLETED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      mode_q        <= MODE_UNINIT;
      tgt_q         <= '0;
      freq_q        <= '0;
      win_len_q     <= '0;
      win_start_q   <= '0;
      open_q        <= '0;
      close_q       <= '0;
      trial_time_q  <= '0;
      trial_bytes_q <= '0;
      count_q       <= '0;
      sum_q         <= '0;
      max_q         <= '0;
      min_q         <= '0;
    end else begin
      if (!in_stall_o) begin
        ev_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= ev_valid_q;
      end
      if (fire) begin
        mode_q        <= mode_d;
        tgt_q         <= tgt_d;
        freq_q        <= freq_d;
        win_len_q     <= win_len_d;
        win_start_q   <= win_start_d;
        open_q        <= open_d;
        close_q       <= close_d;
        trial_time_q  <= trial_time_d;
        trial_bytes_q <= trial_bytes_d;
        count_q       <= count_d;
        sum_q         <= sum_d;
        max_q         <= max_d;
        min_q         <= min_d;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ev_kind_q   <= kind_e'(kind_i);
      ev_ts_q     <= timestamp_i;
      ev_amount_q <= byte_amount_i;
      ev_target_q <= target_bytes_i;
      ev_freq_q   <= timer_frequency_i;
    end
    if (fire) begin
      res_mode_q   <= mode_d;
      res_err_q    <= errs;
      res_newmin_q <= newmin;
    end
  end

  // The stores only change on fire, so they already hold the values after the
  // event that sits in the output register.
  assign out_valid_o     = out_valid_q;
  assign still_testing_o = (res_mode_q == MODE_TESTING);
  assign mode_now_o      = res_mode_q;
  assign error_mask_o    = res_err_q;
  assign new_minimum_o   = res_newmin_q;
  assign trial_count_o   = count_q;
  assign min_ticks_o     = min_q;
  assign max_ticks_o     = max_q;
  assign sum_ticks_o     = sum_q;

endmodule

FILE: design/rtm_checker.sv
// Port-level checker for the repetition timing monitor, bound into repetition_timing_monitor_unit.
// Depends on rtm_pkg and repetition_timing_monitor_unit.
module rtm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       still_testing_o,
  input logic [1:0] mode_now_o,
  input logic [3:0] error_mask_o,
  input logic       new_minimum_o
);
  import rtm_pkg::*;

  // A stalled result word stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_testing_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (still_testing_o == (mode_now_o == MODE_TESTING)))
    else $error("testing flag disagrees with mode");

  // A recorded minimum restarts the window, so the run is still testing and clean.
  a_newmin_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_minimum_o |-> still_testing_o && (error_mask_o == 4'b0000))
    else $error("new minimum reported with error or outside testing");

  // An event that raises an error leaves the run in error or completed.
  a_error_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_mask_o != 4'b0000) |->
      (mode_now_o == MODE_ERROR) || (mode_now_o == MODE_COMPLETED))
    else $error("error raised but mode not error or completed");

endmodule

bind repetition_timing_monitor_unit rtm_checker u_rtm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .still_testing_o (still_testing_o),
  .mode_now_o      (mode_now_o),
  .error_mask_o    (error_mask_o),
  .new_minimum_o   (new_minimum_o)
);

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for repetition_timing_monitor_unit: directed and random event streams.
// Results are checked against a cycle-free status model kept in this file.
// Depends on rtm_pkg and the monitor unit.
module tb;
  import rtm_pkg::*;

  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
  localparam logic [63:0] RUN_TARGET = '1;
  localparam logic [31:0] RUN_FREQ   = 32'd1000;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic        still_testing;
    mode_e       mode;
    logic [3:0]  errs;
    logic        fresh_min;
    logic [63:0] trials;
    logic [63:0] ticks_min;
    logic [63:0] ticks_max;
    logic [63:0] ticks_sum;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        ev_valid = 1'b0;
  logic        ev_stall;
  logic [2:0]  ev_kind = '0;
  logic [63:0] ev_timestamp = '0;
  logic [63:0] ev_bytes = '0;
  logic [63:0] ev_target = '0;
  logic [31:0] ev_freq = '0;
  logic        st_valid;
  logic        st_stall = 1'b0;
  logic        st_testing;
  logic [1:0]  st_mode;
  logic [3:0]  st_errs;
  logic        st_fresh_min;
  logic [63:0] st_trials;
  logic [63:0] st_ticks_min;
  logic [63:0] st_ticks_max;
  logic [63:0] st_ticks_sum;

  // Status model of the monitor.
  mode_e       run_mode = MODE_UNINIT;
  logic [63:0] run_target = '0;
  logic [31:0] run_freq = '0;
  logic [63:0] window_len = '0;
  logic [63:0] window_t0 = '0;
  logic [31:0] opens = '0;
  logic [31:0] closes = '0;
  logic [63:0] trial_ticks = '0;
  logic [63:0] trial_bytes = '0;
  logic [63:0] trial_total = '0;
  logic [63:0] tick_sum = '0;
  logic [63:0] tick_max = '0;
  logic [63:0] tick_min = '0;

  status_t pending_status[$];
  int src_idle_pct = 12;
  int sink_stall_pct = 56;
  int words_sent = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  repetition_timing_monitor_unit i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (ev_valid),
    .in_stall_o        (ev_stall),
    .kind_i            (ev_kind),
    .timestamp_i       (ev_timestamp),
    .byte_amount_i     (ev_bytes),
    .target_bytes_i    (ev_target),
    .timer_frequency_i (ev_freq),
    .out_valid_o       (st_valid),
    .out_stall_i       (st_stall),
    .still_testing_o   (st_testing),
    .mode_now_o        (st_mode),
    .error_mask_o      (st_errs),
    .new_minimum_o     (st_fresh_min),
    .trial_count_o     (st_trials),
    .min_ticks_o       (st_ticks_min),
    .max_ticks_o       (st_ticks_max),
    .sum_ticks_o       (st_ticks_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Applies one event to the status model and returns the status word it yields.
  function automatic status_t status_after(logic [2:0] kind, logic [63:0] ts,
                                           logic [63:0] amount, logic [63:0] target,
                                           logic [31:0] freq);
    status_t res;
    logic [3:0] errs;
    logic fresh_min;
    logic [63:0] elapsed;
    errs = '0;
    fresh_min = 1'b0;
    case (kind)
      KIND_START: begin
        if (run_mode == MODE_UNINIT) begin
          run_mode = MODE_TESTING;
          run_target = target;
          run_freq = freq;
          tick_min = '1;
        end else if (run_mode == MODE_COMPLETED) begin
          run_mode = MODE_TESTING;
          if (run_target != target) errs |= ERR_TARGET;
          if (run_freq != freq) errs |= ERR_FREQ;
          if (errs != '0) run_mode = MODE_ERROR;
        end
        window_len = 64'(freq) * 64'(WINDOW_SECONDS);
        window_t0 = ts;
      end
      KIND_BEGIN: begin
        opens = opens + 32'd1;
        trial_ticks = trial_ticks - ts;
      end
      KIND_END: begin
        closes = closes + 32'd1;
        trial_ticks = trial_ticks + ts;
      end
      KIND_BYTES: trial_bytes = trial_bytes + amount;
      KIND_POLL: begin
        if (run_mode == MODE_TESTING) begin
          if (opens != 32'd0) begin
            if (opens != closes) errs |= ERR_UNBALANCED;
            if (trial_bytes != run_target) errs |= ERR_BYTES;
            if (errs != '0) begin
              run_mode = MODE_ERROR;
            end else begin
              trial_total = trial_total + 64'd1;
              tick_sum = tick_sum + trial_ticks;
              if (tick_max < trial_ticks) tick_max = trial_ticks;
              if (tick_min > trial_ticks) begin
                tick_min = trial_ticks;
                window_t0 = ts;
                fresh_min = 1'b1;
              end
              opens = '0;
              closes = '0;
              trial_ticks = '0;
              trial_bytes = '0;
            end
          end
          // The window is checked even after an error on this poll.
          elapsed = ts - window_t0;
          if (elapsed > window_len) run_mode = MODE_COMPLETED;
        end
      end
      default: ;
    endcase
    res.still_testing = (run_mode == MODE_TESTING);
    res.mode = run_mode;
    res.errs = errs;
    res.fresh_min = fresh_min;
    res.trials = trial_total;
    res.ticks_min = tick_min;
    res.ticks_max = tick_max;
    res.ticks_sum = tick_sum;
    return res;
  endfunction

  // Drives one event word, waits until it is taken and records its expected status.
  task automatic send_event(input logic [2:0] kind, input logic [63:0] ts,
                            input logic [63:0] amount, input logic [63:0] target,
                            input logic [31:0] freq);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      ev_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    ev_valid <= 1'b1;
    ev_kind <= kind;
    ev_timestamp <= ts;
    ev_bytes <= amount;
    ev_target <= target;
    ev_freq <= freq;
    do @(negedge clk); while (ev_stall !== 1'b0);
    @(posedge clk);
    pending_status.push_back(status_after(kind, ts, amount, target, freq));
    if (kind <= KIND_POLL) words_sent++;
  endtask

  task automatic send_spare();
    send_event(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), rand64(), rand64(),
               rand64(), $urandom);
  endtask

  task automatic test_events_before_start();
    send_event(KIND_POLL, 64'd0, rand64(), rand64(), $urandom);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_event(3'(k), rand64(), rand64(), rand64(), $urandom);
    end
    // These pile up into the first trial; its time wraps past zero.
    send_event(KIND_BEGIN, '1, rand64(), rand64(), $urandom);
    send_event(KIND_END, 64'h10_0000, rand64(), rand64(), $urandom);
    send_event(KIND_BYTES, rand64(), RUN_TARGET, rand64(), $urandom);
  endtask

  task automatic test_first_wave();
    send_event(KIND_START, 64'd100, rand64(), RUN_TARGET, RUN_FREQ);
    send_event(KIND_POLL, 64'd200, rand64(), rand64(), $urandom);
    // Restarts while testing only reload the window.
    send_event(KIND_START, 64'd300, rand64(), 64'd0, '1);
    send_event(KIND_START, 64'd400, rand64(), rand64(), 32'd0);
    send_event(KIND_POLL, 64'd400, rand64(), rand64(), $urandom);
    send_event(KIND_POLL, 64'd401, rand64(), rand64(), $urandom);
  endtask

  task automatic test_restart_after_completion();
    send_event(KIND_BEGIN, 64'd1000, rand64(), rand64(), $urandom);
    send_event(KIND_END, 64'd1500, rand64(), rand64(), $urandom);
    send_event(KIND_BYTES, rand64(), RUN_TARGET, rand64(), $urandom);
    send_event(KIND_BYTES, rand64(), 64'd0, rand64(), $urandom);
    send_event(KIND_POLL, 64'd1600, rand64(), rand64(), $urandom);
    send_event(KIND_START, 64'd2000, rand64(), RUN_TARGET, RUN_FREQ);
    send_event(KIND_POLL, 64'd2000, rand64(), rand64(), $urandom);
    // Elapsed time equal to the window does not end the wave; one tick more does.
    send_event(KIND_POLL, 64'd7000, rand64(), rand64(), $urandom);
    send_event(KIND_POLL, 64'd7001, rand64(), rand64(), $urandom);
  endtask

  function automatic logic [63:0] poll_stamp(bit expire);
    if (expire) return window_t0 + window_len + 64'd1 + 64'($urandom_range(0, 999));
    return window_t0 + (rand64() % (window_len + 64'd1));
  endfunction

  // One trial closed by a poll. A broken trial always runs past the window, so the
  // wave ends as completed rather than stuck in error.
  task automatic run_trial(input bit broken);
    int pairs;
    int pieces;
    logic [63:0] begin_ts;
    logic [63:0] dur;
    pairs = $urandom_range(1, 3);
    pieces = $urandom_range(0, 2);
    for (int p = 0; p < pairs; p++) begin
      begin_ts = rand64();
      case ($urandom_range(0, 9))
        0: dur = rand64();
        1: dur = (tick_min > 64'd32 && tick_min != '1) ?
                 tick_min - 64'($urandom_range(1, 31)) : 64'd1;
        default: dur = 64'($urandom_range(1, 2000000));
      endcase
      send_event(KIND_BEGIN, begin_ts, rand64(), rand64(), $urandom);
      if ($urandom_range(0, 7) == 0) send_spare();
      send_event(KIND_END, begin_ts + dur, rand64(), rand64(), $urandom);
    end
    for (int p = 0; p < pieces; p++) begin
      send_event(KIND_BYTES, rand64(), rand64(), rand64(), $urandom);
    end
    // Leftovers of an earlier broken trial are evened out here.
    while (opens != closes) begin
      if (opens > closes) send_event(KIND_END, rand64(), rand64(), rand64(), $urandom);
      else send_event(KIND_BEGIN, rand64(), rand64(), rand64(), $urandom);
    end
    if (broken && $urandom_range(0, 1) == 0) begin
      send_event(KIND_BYTES, rand64(),
                 run_target - trial_bytes + 64'd1 + 64'($urandom_range(0, 99)),
                 rand64(), $urandom);
    end else begin
      send_event(KIND_BYTES, rand64(), run_target - trial_bytes, rand64(), $urandom);
      if (broken) send_event(KIND_BEGIN, rand64(), rand64(), rand64(), $urandom);
    end
    send_event(KIND_POLL, poll_stamp(broken || $urandom_range(0, 6) == 0), rand64(),
               rand64(), $urandom);
  endtask

  task automatic test_random_waves(input int words);
    int stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      if (run_mode == MODE_COMPLETED) begin
        send_event(KIND_START, rand64(), rand64(), run_target, run_freq);
      end else if ($urandom_range(0, 9) == 0) begin
        send_event(KIND_START, rand64(), rand64(), rand64(),
                   ($urandom_range(0, 2) == 0) ? $urandom : run_freq);
      end
      if (opens == 32'd0 && $urandom_range(0, 9) == 0) begin
        send_event(KIND_POLL, poll_stamp($urandom_range(0, 2) == 0), rand64(), rand64(),
                   $urandom);
      end else begin
        run_trial($urandom_range(0, 9) == 0);
      end
    end
  endtask

  // The error mode is never left, so this runs last.
  task automatic test_error_mode();
    while (run_mode == MODE_TESTING) begin
      send_event(KIND_POLL, poll_stamp(1'b1), rand64(), rand64(), $urandom);
    end
    send_event(KIND_START, rand64(), rand64(), ~run_target, run_freq ^ 32'd1);
    send_event(KIND_START, rand64(), rand64(), rand64(), 32'd0);
    send_event(KIND_BEGIN, rand64(), rand64(), rand64(), $urandom);
    send_event(KIND_END, rand64(), rand64(), rand64(), $urandom);
    send_event(KIND_BYTES, rand64(), run_target - trial_bytes, rand64(), $urandom);
    send_event(KIND_POLL, poll_stamp(1'b1), rand64(), rand64(), $urandom);
    send_spare();
  endtask

  always @(posedge clk) begin
    st_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Outputs are sampled mid-cycle; a word sampled here is taken at the next rising edge.
  always @(negedge clk) begin : check_status
    status_t exp;
    if (rst_n && st_valid === 1'b1 && st_stall == 1'b0) begin
      if (pending_status.size() == 0) begin
        $error("status word with none expected");
        mismatches++;
      end else begin
        exp = pending_status.pop_front();
        if (st_testing !== exp.still_testing) begin
          $error("still_testing: expected %0d, got %0d", exp.still_testing, st_testing);
          mismatches++;
        end
        if (st_mode !== exp.mode) begin
          $error("mode_now: expected %0d, got %0d", exp.mode, st_mode);
          mismatches++;
        end
        if (st_errs !== exp.errs) begin
          $error("error_mask: expected %h, got %h", exp.errs, st_errs);
          mismatches++;
        end
        if (st_fresh_min !== exp.fresh_min) begin
          $error("new_minimum: expected %0d, got %0d", exp.fresh_min, st_fresh_min);
          mismatches++;
        end
        if (st_trials !== exp.trials) begin
          $error("trial_count: expected %h, got %h", exp.trials, st_trials);
          mismatches++;
        end
        if (st_ticks_min !== exp.ticks_min) begin
          $error("min_ticks: expected %h, got %h", exp.ticks_min, st_ticks_min);
          mismatches++;
        end
        if (st_ticks_max !== exp.ticks_max) begin
          $error("max_ticks: expected %h, got %h", exp.ticks_max, st_ticks_max);
          mismatches++;
        end
        if (st_ticks_sum !== exp.ticks_sum) begin
          $error("sum_ticks: expected %h, got %h", exp.ticks_sum, st_ticks_sum);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((ev_valid && ev_stall === 1'b0) || (st_valid === 1'b1 && !st_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_events_before_start();
    test_first_wave();
    test_restart_after_completion();
    test_random_waves(150);
    src_idle_pct = 56;
    sink_stall_pct = 12;
    test_random_waves(150);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    test_random_waves(150);
    test_error_mode();
    ev_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
